// File: hdl/sdv_pkg.sv
// Shared types and status codes for the surface descriptor validator.
`timescale 1ns / 1ps

package sdv_pkg;

    localparam int unsigned DVD_W     = 64;
    localparam int unsigned ALIGN_W   = 32;
    localparam int unsigned STATUS_W  = 4;
    localparam int unsigned DIV_STEPS = DVD_W;

    localparam logic [STATUS_W-1:0] ST_OK               = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIM         = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_BPP         = 4'd2;
    localparam logic [STATUS_W-1:0] ST_LOGICAL_OVF      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_LOGICAL_MISMATCH = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_PITCH       = 4'd5;
    localparam logic [STATUS_W-1:0] ST_PITCH_NARROW     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_PITCH_OVF        = 4'd7;
    localparam logic [STATUS_W-1:0] ST_PITCH_MISMATCH   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_ZERO_ALIGN       = 4'd9;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED       = 4'd10;
    localparam logic [STATUS_W-1:0] ST_ZERO_SURFACE     = 4'd11;
    localparam logic [STATUS_W-1:0] ST_SURFACE_OVF      = 4'd12;
    localparam logic [STATUS_W-1:0] ST_SURFACE_MISMATCH = 4'd13;

    // Word carried along the remainder chain.
    typedef struct packed {
        logic [ALIGN_W-1:0]  rem;
        logic [DVD_W-1:0]    dvd;
        logic [ALIGN_W-1:0]  align;
        logic [STATUS_W-1:0] pre;
        logic [STATUS_W-1:0] post;
    } sdv_cell_t;

endpackage

// File: hdl/surface_descriptor_validator.sv
// Top level: front end, remainder cell chain and output register with skid.
//
//  channel   handshake              payload
//  request   req_valid / req_ready  image_width .. surface_bytes
//  response  rsp_valid / rsp_ready  status
//
// One word is accepted per cycle while no skid word is held; the path holds three front-end stages,
// 64 remainder cells (one dividend bit each) and the output register.
// The whole pipeline advances together and stops only when the skid word is held.
// req_ready stays high while one finished word waits at the output.
// Reset clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module surface_descriptor_validator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [31:0] image_width,
    input  logic [31:0] image_height,
    input  logic [31:0] pixel_bytes,
    input  logic [63:0] logical_bytes,
    input  logic [31:0] row_pitch_pixels,
    input  logic [31:0] row_pitch_bytes,
    input  logic [31:0] align_bytes,
    input  logic [63:0] base_addr,
    input  logic [63:0] surface_bytes,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [3:0]  status
);
    import sdv_pkg::*;

    logic                en;
    logic                chain_valid [DIV_STEPS+1];
    sdv_cell_t           chain_cell  [DIV_STEPS+1];
    logic [STATUS_W-1:0] final_status;
    logic                last_valid;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [STATUS_W-1:0] skid_status_reg, skid_status_next;

    assign en        = !skid_valid_reg;
    assign req_ready = en;

    sdv_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (req_valid),
        .image_width      (image_width),
        .image_height     (image_height),
        .pixel_bytes      (pixel_bytes),
        .logical_bytes    (logical_bytes),
        .row_pitch_pixels (row_pitch_pixels),
        .row_pitch_bytes  (row_pitch_bytes),
        .align_bytes      (align_bytes),
        .base_addr        (base_addr),
        .surface_bytes    (surface_bytes),
        .out_valid        (chain_valid[0]),
        .out_cell         (chain_cell[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        sdv_mod_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    always_comb
    begin
        if (chain_cell[DIV_STEPS].pre != ST_OK)
            final_status = chain_cell[DIV_STEPS].pre;
        else if (chain_cell[DIV_STEPS].rem != '0)
            final_status = ST_MISALIGNED;
        else
            final_status = chain_cell[DIV_STEPS].post;
    end

    assign last_valid = en && chain_valid[DIV_STEPS];

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_status_next = skid_status_reg;
        if (skid_valid_reg)
        begin
            if (rsp_ready)
            begin
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || rsp_ready)
        begin
            out_valid_next  = last_valid;
            out_status_next = final_status;
        end
        else if (last_valid)
        begin
            skid_valid_next  = 1'b1;
            skid_status_next = final_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        skid_status_reg <= skid_status_next;
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !rsp_ready))
        else $error("skid filled while the output was free");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_SURFACE_MISMATCH))
        else $error("status code out of range");
`endif

endmodule

// File: hdl/sdv_front.sv
// Three-stage front end: products, size compares and the early status codes.
`timescale 1ns / 1ps

module sdv_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [31:0]          image_width,
    input  logic [31:0]          image_height,
    input  logic [31:0]          pixel_bytes,
    input  logic [63:0]          logical_bytes,
    input  logic [31:0]          row_pitch_pixels,
    input  logic [31:0]          row_pitch_bytes,
    input  logic [31:0]          align_bytes,
    input  logic [63:0]          base_addr,
    input  logic [63:0]          surface_bytes,
    output logic                 out_valid,
    output sdv_pkg::sdv_cell_t   out_cell
);
    import sdv_pkg::*;

    typedef struct packed {
        logic zdim;
        logic zbpp;
        logic zpitch;
        logic narrow;
        logic zalign;
        logic zsurf;
    } sdv_flags_t;

    // Stage one.
    logic        v1_reg;
    logic [63:0] wh_reg, pp_reg, sh_reg, lb1_reg, base1_reg, sb1_reg;
    logic [31:0] bpp1_reg, pby1_reg, al1_reg;
    sdv_flags_t  f1_reg;
    // Stage two.
    logic        v2_reg;
    logic [63:0] hi_reg, lo_reg, lb2_reg, base2_reg;
    logic [31:0] al2_reg;
    logic        povf2_reg, pmis2_reg, smis2_reg;
    sdv_flags_t  f2_reg;
    // Stage three.
    logic        v3_reg;
    sdv_cell_t   c3_reg, c3_next;

    logic [32:0] sum;
    logic        log_ovf, log_mis;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wh_reg        <= 64'(image_width) * 64'(image_height);
            pp_reg        <= 64'(row_pitch_pixels) * 64'(pixel_bytes);
            sh_reg        <= 64'(row_pitch_bytes) * 64'(image_height);
            lb1_reg       <= logical_bytes;
            base1_reg     <= base_addr;
            sb1_reg       <= surface_bytes;
            bpp1_reg      <= pixel_bytes;
            pby1_reg      <= row_pitch_bytes;
            al1_reg       <= align_bytes;
            f1_reg.zdim   <= (image_width == 32'd0) || (image_height == 32'd0);
            f1_reg.zbpp   <= (pixel_bytes == 32'd0);
            f1_reg.zpitch <= (row_pitch_pixels == 32'd0) || (row_pitch_bytes == 32'd0);
            f1_reg.narrow <= (row_pitch_pixels < image_width);
            f1_reg.zalign <= (align_bytes == 32'd0);
            f1_reg.zsurf  <= (surface_bytes == 64'd0);

            // The 64 by 32 logical product is split into two 32 by 32 halves.
            hi_reg    <= 64'(wh_reg[63:32]) * 64'(bpp1_reg);
            lo_reg    <= 64'(wh_reg[31:0]) * 64'(bpp1_reg);
            lb2_reg   <= lb1_reg;
            base2_reg <= base1_reg;
            al2_reg   <= al1_reg;
            povf2_reg <= (pp_reg[63:32] != 32'd0);
            pmis2_reg <= ({32'd0, pby1_reg} != pp_reg);
            smis2_reg <= (sb1_reg != sh_reg);
            f2_reg    <= f1_reg;

            c3_reg <= c3_next;
        end
    end

    always_comb
    begin
        sum     = {1'b0, hi_reg[31:0]} + {1'b0, lo_reg[63:32]};
        log_ovf = (hi_reg[63:32] != 32'd0) || sum[32];
        log_mis = (lb2_reg != {sum[31:0], lo_reg[31:0]});

        c3_next.rem   = '0;
        c3_next.dvd   = base2_reg;
        c3_next.align = al2_reg;

        if (f2_reg.zdim)
            c3_next.pre = ST_ZERO_DIM;
        else if (f2_reg.zbpp)
            c3_next.pre = ST_ZERO_BPP;
        else if (log_ovf)
            c3_next.pre = ST_LOGICAL_OVF;
        else if (log_mis)
            c3_next.pre = ST_LOGICAL_MISMATCH;
        else if (f2_reg.zpitch)
            c3_next.pre = ST_ZERO_PITCH;
        else if (f2_reg.narrow)
            c3_next.pre = ST_PITCH_NARROW;
        else if (povf2_reg)
            c3_next.pre = ST_PITCH_OVF;
        else if (pmis2_reg)
            c3_next.pre = ST_PITCH_MISMATCH;
        else if (f2_reg.zalign)
            c3_next.pre = ST_ZERO_ALIGN;
        else
            c3_next.pre = ST_OK;

        // A 32 by 32 surface product always fits, so no overflow code here.
        if (f2_reg.zsurf)
            c3_next.post = ST_ZERO_SURFACE;
        else if (smis2_reg)
            c3_next.post = ST_SURFACE_MISMATCH;
        else
            c3_next.post = ST_OK;
    end

    assign out_valid = v3_reg;
    assign out_cell  = c3_reg;

endmodule

// File: hdl/sdv_mod_cell.sv
// One restoring remainder step of the base address by the alignment.
`timescale 1ns / 1ps

module sdv_mod_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  sdv_pkg::sdv_cell_t   in_cell,
    output logic                 out_valid,
    output sdv_pkg::sdv_cell_t   out_cell
);
    import sdv_pkg::*;

    logic                valid_reg;
    sdv_cell_t           cell_reg, cell_next;
    logic [ALIGN_W:0]    part;
    logic [ALIGN_W:0]    diff;

    always_comb
    begin
        part = {in_cell.rem, in_cell.dvd[DVD_W-1]};
        diff = part - {1'b0, in_cell.align};
        cell_next     = in_cell;
        cell_next.dvd = {in_cell.dvd[DVD_W-2:0], 1'b0};
        if (part >= {1'b0, in_cell.align})
            cell_next.rem = diff[ALIGN_W-1:0];
        else
            cell_next.rem = part[ALIGN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the surface descriptor validator.
`timescale 1ns / 1ps

module testbench;
    import sdv_pkg::*;

    localparam int LATENCY     = 68;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] pixel_bytes;
    logic [63:0] logical_bytes;
    logic [31:0] row_pitch_pixels;
    logic [31:0] row_pitch_bytes;
    logic [31:0] align_bytes;
    logic [63:0] base_addr;
    logic [63:0] surface_bytes;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [3:0]  status;

    typedef struct {
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] bpp;
        logic [63:0] lb;
        logic [31:0] ppx;
        logic [31:0] pby;
        logic [31:0] al;
        logic [63:0] base;
        logic [63:0] sb;
    } descriptor_t;

    logic [3:0] expected_status_q[$];
    int         error_count;
    int         cycle_count;
    bit         long_hold;
    bit         stall_enable;

    surface_descriptor_validator i_dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Full-width products, so overflow shows in the upper bits.
    function automatic logic [3:0] predict_status(descriptor_t d);
        logic [127:0] logical;
        logic [63:0]  pitch;
        logic [63:0]  surf;
        if (d.w == 0 || d.h == 0)
            return ST_ZERO_DIM;
        if (d.bpp == 0)
            return ST_ZERO_BPP;
        logical = 128'(d.w) * 128'(d.h) * 128'(d.bpp);
        if (logical[127:64] != 0)
            return ST_LOGICAL_OVF;
        if (d.lb != logical[63:0])
            return ST_LOGICAL_MISMATCH;
        if (d.ppx == 0 || d.pby == 0)
            return ST_ZERO_PITCH;
        if (d.ppx < d.w)
            return ST_PITCH_NARROW;
        pitch = 64'(d.ppx) * 64'(d.bpp);
        if (pitch[63:32] != 0)
            return ST_PITCH_OVF;
        if (64'(d.pby) != pitch)
            return ST_PITCH_MISMATCH;
        if (d.al == 0)
            return ST_ZERO_ALIGN;
        if ((d.base % 64'(d.al)) != 0)
            return ST_MISALIGNED;
        if (d.sb == 0)
            return ST_ZERO_SURFACE;
        surf = 64'(d.pby) * 64'(d.h);
        if (d.sb != surf)
            return ST_SURFACE_MISMATCH;
        return ST_OK;
    endfunction

    task automatic send_descriptor(descriptor_t d);
        req_valid        <= 1'b1;
        image_width      <= d.w;
        image_height     <= d.h;
        pixel_bytes      <= d.bpp;
        logical_bytes    <= d.lb;
        row_pitch_pixels <= d.ppx;
        row_pitch_bytes  <= d.pby;
        align_bytes      <= d.al;
        base_addr        <= d.base;
        surface_bytes    <= d.sb;
        do
            @(posedge clk);
        while (!req_ready);
        expected_status_q.insert(expected_status_q.size(), predict_status(d));
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Small random sizes keep the products well inside range.
    function automatic descriptor_t valid_descriptor();
        descriptor_t d;
        logic [63:0] tmp;
        d.w    = $urandom_range(1, 4096);
        d.h    = $urandom_range(1, 4096);
        d.bpp  = $urandom_range(1, 16);
        d.lb   = 64'(d.w) * 64'(d.h) * 64'(d.bpp);
        d.ppx  = d.w + $urandom_range(0, 64);
        d.pby  = d.ppx * d.bpp;
        d.al   = 32'd1 << $urandom_range(0, 12);
        tmp    = rand64();
        d.base = tmp - (tmp % 64'(d.al));
        d.sb   = 64'(d.pby) * 64'(d.h);
        return d;
    endfunction

    // Starts from a good descriptor and may break one check, randomize every field or keep it valid.
    function automatic descriptor_t random_descriptor();
        descriptor_t d;
        d = valid_descriptor();
        case ($urandom_range(0, 19))
            0:  d.w = 0;
            1:  d.h = 0;
            2:  d.bpp = 0;
            3:
            begin
                d.w = $urandom() | 32'h8000_0000;
                d.h = $urandom() | 32'h8000_0000;
                d.bpp = $urandom_range(2, 32'hFFFF_FFFF);
                d.lb = rand64();
            end
            4:  d.lb = d.lb ^ (64'd1 << $urandom_range(0, 63));
            5:  d.ppx = 0;
            6:  d.pby = 0;
            7:  d.ppx = d.w - 1;
            8:
            begin
                d.bpp = 32'h1_0000 | $urandom();
                d.lb = 64'(d.w) * 64'(d.h) * 64'(d.bpp);
            end
            9:  d.pby = d.pby ^ (32'd1 << $urandom_range(0, 31));
            10: d.al = 0;
            11:
            begin
                d.al = $urandom() | 32'd2;
                d.base = rand64();
            end
            12: d.sb = 0;
            13: d.sb = d.sb ^ (64'd1 << $urandom_range(0, 63));
            14:
            begin
                d.w = $urandom(); d.h = $urandom(); d.bpp = $urandom();
                d.lb = rand64(); d.ppx = $urandom(); d.pby = $urandom();
                d.al = $urandom(); d.base = rand64(); d.sb = rand64();
            end
            15:
            begin
                d.al = $urandom() | 32'h8000_0000;
                d.base = 64'(d.al) * 64'($urandom());
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic test_directed();
        descriptor_t d;
        d = valid_descriptor();
        send_descriptor(d);
        d.w = 0; send_descriptor(d);
        d = valid_descriptor(); d.h = 0; send_descriptor(d);
        d = valid_descriptor(); d.bpp = 0; send_descriptor(d);
        d = valid_descriptor();
        d.w = '1; d.h = '1; d.bpp = '1; d.lb = '1; send_descriptor(d);
        d.w = '1; d.h = '1; d.bpp = 1;
        d.lb = 64'(d.w) * 64'(d.h); d.ppx = '1; d.pby = '1;
        d.al = 1; d.base = '1; d.sb = 64'(d.pby) * 64'(d.h);
        send_descriptor(d);
        d.sb = 0; send_descriptor(d);
        d.sb = '1; send_descriptor(d);
        d.al = '1; d.base = '1; d.sb = 64'(d.pby) * 64'(d.h);
        send_descriptor(d);
        d.base = 64'hFFFF_FFFE_0000_0001; send_descriptor(d);
        d.al = 0; send_descriptor(d);
        d = valid_descriptor(); d.lb = d.lb + 1; send_descriptor(d);
        d = valid_descriptor(); d.ppx = 0; send_descriptor(d);
        d = valid_descriptor(); d.pby = 0; send_descriptor(d);
        d = valid_descriptor(); d.ppx = d.w - 1; send_descriptor(d);
        d = valid_descriptor();
        d.w = 1; d.h = 1; d.bpp = 32'h1_0000; d.lb = 64'h1_0000;
        d.ppx = 32'h1_0000; send_descriptor(d);
        d.ppx = 32'hFFFF; d.pby = 32'hFFFF_0000; d.sb = 64'hFFFF_0000;
        send_descriptor(d);
        d.pby = 32'hFFFF_0001; send_descriptor(d);
        d = valid_descriptor(); d.base = 64'h1; d.al = 2; send_descriptor(d);
        d = valid_descriptor(); d.sb = d.sb - 1; send_descriptor(d);
        d = valid_descriptor(); d.base = 0; send_descriptor(d);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_descriptor(random_descriptor());
            if ($urandom_range(0, 7) == 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    // The receiver holds off long enough for the pipeline and skid to fill.
    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 150; i++)
            send_descriptor(random_descriptor());
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || long_hold)
            rsp_ready <= 1'b0;
        else if (stall_enable)
            rsp_ready <= (($urandom() % 16) < 11);
        else
            rsp_ready <= 1'b1;
    end

    always @(negedge clk)
    begin
        if (long_hold)
        begin
            repeat (300) @(negedge clk);
            long_hold = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                $error("status: no result expected, actual %0d", status);
                error_count++;
            end
            else
            begin
                logic [3:0] exp_status;
                exp_status = expected_status_q.pop_front();
                if (status !== exp_status)
                begin
                    $error("status: expected %0d, actual %0d", exp_status, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        long_hold = 1'b0;
        stall_enable = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        rsp_ready = 1'b0;
        image_width = '0;
        image_height = '0;
        pixel_bytes = '0;
        logical_bytes = '0;
        row_pitch_pixels = '0;
        row_pitch_bytes = '0;
        align_bytes = '0;
        base_addr = '0;
        surface_bytes = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(300);
        stall_enable = 1'b1;
        test_random(600);
        test_backpressure();
        test_random(600);
        req_valid <= 1'b0;
        stall_enable = 1'b0;
        while (expected_status_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
